### rtl/clp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_pkg: shared types and constants of the command line preformatter
// Lexer modes, character codes and the result bundle that travels from the
// front part through the queue to the back part.
// ----------------------------------------------------------------------------
package clp_pkg;

   typedef enum logic [2:0] {
      MODE_SKIP    = 3'd0,
      MODE_NORMAL  = 3'd1,
      MODE_SPACE   = 3'd2,
      MODE_ESC     = 3'd3,
      MODE_CARET   = 3'd4,
      MODE_NAME    = 3'd5,
      MODE_COMMENT = 3'd6
   } lex_mode_type;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
   localparam logic [7:0] CHAR_STAR      = 8'h2A;
   localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
   localparam logic [7:0] CHAR_QUESTION  = 8'h3F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_CARET     = 8'h5E;
   localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;
   localparam logic [7:0] CHAR_BAR       = 8'h7C;
   localparam logic [7:0] MARKER         = 8'h80;
   localparam logic [7:0] CARET_MASK     = 8'h1F;

   // Up to three result bytes caused by one input item, lowest slot first.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] data;
      logic [2:0]      ends;
   } bundle_type;

endpackage

### rtl/command_line_preformatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_preformatter: command line to tokenizer byte stream
// Front lexer, bundle queue and result serialiser.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_in_byte
//   rsp       out        rsp_valid/rsp_stall   rsp_out_byte, rsp_last_of_run,
//                                              rsp_line_end
//
// The front accepts one byte per cycle while the queue has room; each byte
// yields zero to three results, sent one per cycle by the back part unless
// rsp stalls. A bundle is written to a queue slot and then loaded into the
// output register. Sustained rate is set by the single output register:
// one result per cycle unless rsp stalls. Reset (synchronous) empties the
// queue and returns the lexer to skipping leading blanks outside quotes.
// A stall on rsp fills the queue and then raises req_stall.
// ----------------------------------------------------------------------------
module command_line_preformatter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   output logic       rsp_line_end
);

   logic                push;
   clp_pkg::bundle_type push_data;
   logic                full;
   logic                pop;
   clp_pkg::bundle_type pop_data;
   logic                empty;

   clp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .queue_full  (full),
      .push        (push),
      .push_data   (push_data)
   );

   clp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   clp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (empty),
      .queue_data      (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_line_end    (rsp_line_end)
   );

endmodule

### rtl/clp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_front: lexer front part
// Accepts one byte per cycle if the queue has room, tracks quote and lexer
// mode, and turns each byte into a queue bundle of up to three result bytes.
// ----------------------------------------------------------------------------
module clp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                queue_full,
   output logic                push,
   output clp_pkg::bundle_type push_data
);

   clp_pkg::lex_mode_type mode_ff, mode_in;
   logic                  quotes_ff, quotes_in;

   logic                  accept;
   logic [7:0]            b;
   logic                  blank;
   logic                  has_pre;
   logic [7:0]            pre_byte;
   logic                  use_normal;
   logic [1:0]            nrm_count;
   logic [1:0][7:0]       nrm_data;
   logic [1:0]            nrm_ends;
   clp_pkg::lex_mode_type nrm_mode;
   logic                  nrm_quotes;
   logic                  name_byte;

   assign accept    = req_valid & ~queue_full;
   assign req_stall = queue_full;
   assign b         = req_in_byte;
   assign blank     = (b == clp_pkg::CHAR_SPACE) || (b == clp_pkg::CHAR_TAB);
   assign name_byte = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
                      (b >= 8'h41 && b <= 8'h5A) || (b == clp_pkg::CHAR_UNDERLINE);

   // Normal-mode handling of the current byte: at most two result bytes.
   always_comb begin
      nrm_count  = 2'd0;
      nrm_data   = '0;
      nrm_ends   = 2'b00;
      nrm_mode   = clp_pkg::MODE_NORMAL;
      nrm_quotes = quotes_ff;
      if (b == clp_pkg::CHAR_NUL) begin
         nrm_count  = 2'd2;
         nrm_ends   = 2'b10;
         nrm_mode   = clp_pkg::MODE_SKIP;
         nrm_quotes = 1'b0;
      end else if (quotes_ff && b != clp_pkg::CHAR_QUOTE && b != clp_pkg::CHAR_BACKSLASH) begin
         nrm_count   = 2'd1;
         nrm_data[0] = b | clp_pkg::MARKER;
      end else begin
         case (b)
            clp_pkg::CHAR_SPACE, clp_pkg::CHAR_TAB: begin
               nrm_mode = clp_pkg::MODE_SPACE;
            end
            clp_pkg::CHAR_STAR, clp_pkg::CHAR_QUESTION: begin
               nrm_count   = 2'd2;
               nrm_data[0] = clp_pkg::MARKER;
               nrm_data[1] = b;
            end
            clp_pkg::CHAR_HASH: begin
               nrm_count = 2'd1;
               nrm_mode  = clp_pkg::MODE_COMMENT;
            end
            clp_pkg::CHAR_SEMICOLON, clp_pkg::CHAR_BAR: begin
               nrm_count   = 2'd1;
               nrm_data[0] = b;
               nrm_mode    = clp_pkg::MODE_SKIP;
            end
            clp_pkg::CHAR_BACKSLASH: begin
               nrm_mode = clp_pkg::MODE_ESC;
            end
            clp_pkg::CHAR_QUOTE: begin
               nrm_quotes = ~quotes_ff;
            end
            clp_pkg::CHAR_CARET: begin
               nrm_mode = clp_pkg::MODE_CARET;
            end
            clp_pkg::CHAR_DOLLAR: begin
               nrm_count   = 2'd2;
               nrm_data[0] = clp_pkg::MARKER;
               nrm_data[1] = b;
               nrm_mode    = clp_pkg::MODE_NAME;
            end
            default: begin
               nrm_count   = 2'd1;
               nrm_data[0] = b;
            end
         endcase
      end
   end

   // Per-mode prefix byte and next state; the remainder goes through normal handling.
   always_comb begin
      has_pre    = 1'b0;
      pre_byte   = '0;
      use_normal = 1'b0;
      mode_in    = mode_ff;
      quotes_in  = quotes_ff;
      case (mode_ff)
         clp_pkg::MODE_SKIP: begin
            use_normal = ~blank;
         end
         clp_pkg::MODE_SPACE: begin
            use_normal = ~blank;
            has_pre    = ~blank && b != clp_pkg::CHAR_NUL && b != clp_pkg::CHAR_SEMICOLON &&
                         b != clp_pkg::CHAR_BAR;
            pre_byte   = clp_pkg::CHAR_SPACE;
         end
         clp_pkg::MODE_ESC: begin
            has_pre    = 1'b1;
            pre_byte   = b | clp_pkg::MARKER;
            use_normal = (b == clp_pkg::CHAR_NUL);
            mode_in    = clp_pkg::MODE_NORMAL;
         end
         clp_pkg::MODE_CARET: begin
            has_pre    = 1'b1;
            pre_byte   = b & clp_pkg::CARET_MASK;
            use_normal = (b == clp_pkg::CHAR_NUL);
            mode_in    = clp_pkg::MODE_NORMAL;
         end
         clp_pkg::MODE_NAME: begin
            if (name_byte) begin
               has_pre  = 1'b1;
               pre_byte = b;
            end else begin
               has_pre    = 1'b1;
               pre_byte   = clp_pkg::MARKER;
               use_normal = 1'b1;
            end
         end
         clp_pkg::MODE_COMMENT: begin
            use_normal = (b == clp_pkg::CHAR_NUL);
         end
         default: begin
            use_normal = 1'b1;
         end
      endcase
      if (use_normal) begin
         mode_in   = nrm_mode;
         quotes_in = nrm_quotes;
      end
   end

   // Assemble the bundle: prefix byte first, then the normal-mode bytes.
   always_comb begin
      logic [1:0]      n_cnt;
      logic [1:0][7:0] n_dat;
      logic [1:0]      n_end;
      n_cnt = use_normal ? nrm_count : 2'd0;
      n_dat = nrm_data;
      n_end = use_normal ? nrm_ends : 2'b00;
      push_data = '0;
      if (has_pre) begin
         push_data.count   = 2'(n_cnt + 2'd1);
         push_data.data[0] = pre_byte;
         push_data.data[1] = n_dat[0];
         push_data.data[2] = n_dat[1];
         push_data.ends    = {n_end, 1'b0};
      end else begin
         push_data.count   = n_cnt;
         push_data.data[0] = n_dat[0];
         push_data.data[1] = n_dat[1];
         push_data.ends    = {1'b0, n_end};
      end
      push = accept && (push_data.count != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= clp_pkg::MODE_SKIP;
         quotes_ff <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         quotes_ff <= quotes_in;
      end
   end

endmodule

### rtl/clp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_queue: bundle queue between front and back
// Small register FIFO of result bundles with occupancy count.
// ----------------------------------------------------------------------------
module clp_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  clp_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output clp_pkg::bundle_type pop_data,
   output logic                empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   clp_pkg::bundle_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/clp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_back: result serialiser
// Holds one bundle in an output register and presents its bytes one per
// cycle while rsp is not stalled, marking the last byte of each bundle.
// ----------------------------------------------------------------------------
module clp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  clp_pkg::bundle_type queue_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_of_run,
   output logic                rsp_line_end
);

   logic                have_ff, have_in;
   clp_pkg::bundle_type bundle_ff, bundle_in;
   logic [1:0]          pos_ff, pos_in;
   logic                taken;
   logic                last;

   assign rsp_valid       = have_ff;
   assign taken           = have_ff & ~rsp_stall;
   assign last            = (pos_ff == 2'(bundle_ff.count - 2'd1));
   assign rsp_out_byte    = bundle_ff.data[pos_ff];
   assign rsp_line_end    = bundle_ff.ends[pos_ff];
   assign rsp_last_of_run = last;

   always_comb begin
      pop       = (!have_ff || (taken && last)) && !queue_empty;
      have_in   = have_ff;
      bundle_in = bundle_ff;
      pos_in    = pos_ff;
      if (pop) begin
         have_in   = 1'b1;
         bundle_in = queue_data;
         pos_in    = 2'd0;
      end else if (taken) begin
         if (last) begin
            have_in = 1'b0;
         end else begin
            pos_in = 2'(pos_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         pos_ff  <= 2'd0;
      end else begin
         have_ff <= have_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      bundle_ff <= bundle_in;
   end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the command line preformatter
// Feeds directed and random command lines through the byte channel, predicts
// every output byte with an independent lexer model kept in a scoreboard, and
// compares each accepted result in order, with random idling on both sides.
// ----------------------------------------------------------------------------

typedef struct {
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       line_end;
} formatted_byte_type;

localparam logic [7:0] LOWER_A = 8'h61;
localparam logic [7:0] UPPER_A = 8'h41;
localparam logic [7:0] DIGIT_0 = 8'h30;

class line_scoreboard;
   clp_pkg::lex_mode_type mode;
   logic                  quoted;
   logic [7:0]            run_bytes[$];
   logic                  run_ends[$];
   formatted_byte_type    pending[$];
   int                    errors;

   function new();
      mode = clp_pkg::MODE_SKIP;
      quoted = 1'b0;
      errors = 0;
   endfunction

   task report(string what);
      errors++;
      if (errors <= 50) $display("mismatch: %s", what);
   endtask

   function void emit(logic [7:0] b, logic e);
      run_bytes.push_back(b);
      run_ends.push_back(e);
   endfunction

   function void close_line();
      emit(clp_pkg::CHAR_NUL, 1'b0);
      emit(clp_pkg::CHAR_NUL, 1'b1);
      quoted = 1'b0;
      mode = clp_pkg::MODE_SKIP;
   endfunction

   function bit is_blank(logic [7:0] b);
      return b == clp_pkg::CHAR_SPACE || b == clp_pkg::CHAR_TAB;
   endfunction

   function bit is_name_char(logic [7:0] b);
      return (b >= DIGIT_0 && b <= DIGIT_0 + 8'd9) ||
             (b >= LOWER_A && b <= LOWER_A + 8'd25) ||
             (b >= UPPER_A && b <= UPPER_A + 8'd25) || b == clp_pkg::CHAR_UNDERLINE;
   endfunction

   function void plain(logic [7:0] b);
      mode = clp_pkg::MODE_NORMAL;
      if (b == clp_pkg::CHAR_NUL) begin
         close_line();
         return;
      end
      // quote and backslash keep their meaning inside quotes
      if (quoted && b != clp_pkg::CHAR_QUOTE && b != clp_pkg::CHAR_BACKSLASH) begin
         emit(b | clp_pkg::MARKER, 1'b0);
         return;
      end
      case (b)
         clp_pkg::CHAR_SPACE, clp_pkg::CHAR_TAB: mode = clp_pkg::MODE_SPACE;
         clp_pkg::CHAR_STAR, clp_pkg::CHAR_QUESTION: begin
            emit(clp_pkg::MARKER, 1'b0);
            emit(b, 1'b0);
         end
         clp_pkg::CHAR_HASH: begin
            emit(clp_pkg::CHAR_NUL, 1'b0);
            mode = clp_pkg::MODE_COMMENT;
         end
         clp_pkg::CHAR_SEMICOLON, clp_pkg::CHAR_BAR: begin
            emit(b, 1'b0);
            mode = clp_pkg::MODE_SKIP;
         end
         clp_pkg::CHAR_BACKSLASH: mode = clp_pkg::MODE_ESC;
         clp_pkg::CHAR_QUOTE: quoted = !quoted;
         clp_pkg::CHAR_CARET: mode = clp_pkg::MODE_CARET;
         clp_pkg::CHAR_DOLLAR: begin
            emit(clp_pkg::MARKER, 1'b0);
            emit(b, 1'b0);
            mode = clp_pkg::MODE_NAME;
         end
         default: emit(b, 1'b0);
      endcase
   endfunction

   function void note_byte(logic [7:0] b);
      int n;
      formatted_byte_type r;
      run_bytes.delete();
      run_ends.delete();
      case (mode)
         clp_pkg::MODE_SKIP: if (!is_blank(b)) plain(b);
         clp_pkg::MODE_SPACE: begin
            if (!is_blank(b)) begin
               // drop the pending space before end of line and separators
               if (b != clp_pkg::CHAR_NUL && b != clp_pkg::CHAR_SEMICOLON &&
                   b != clp_pkg::CHAR_BAR)
                  emit(clp_pkg::CHAR_SPACE, 1'b0);
               plain(b);
            end
         end
         clp_pkg::MODE_ESC: begin
            emit(b | clp_pkg::MARKER, 1'b0);
            mode = clp_pkg::MODE_NORMAL;
            if (b == clp_pkg::CHAR_NUL) close_line();
         end
         clp_pkg::MODE_CARET: begin
            emit(b & clp_pkg::CARET_MASK, 1'b0);
            mode = clp_pkg::MODE_NORMAL;
            if (b == clp_pkg::CHAR_NUL) close_line();
         end
         clp_pkg::MODE_NAME: begin
            if (is_name_char(b)) begin
               emit(b, 1'b0);
            end else begin
               emit(clp_pkg::MARKER, 1'b0);
               plain(b);
            end
         end
         clp_pkg::MODE_COMMENT: if (b == clp_pkg::CHAR_NUL) close_line();
         default: plain(b);
      endcase
      n = run_bytes.size() > 3 ? 3 : run_bytes.size();
      for (int k = 0; k < n; k++) begin
         r.out_byte = run_bytes[k];
         r.last_of_run = (k == n - 1);
         r.line_end = run_ends[k];
         pending.push_back(r);
      end
   endfunction

   task check(logic [7:0] b, logic last, logic le);
      formatted_byte_type want;
      if (pending.size() == 0) begin
         report($sformatf("unexpected result byte %02h last %0b end %0b", b, last, le));
         return;
      end
      want = pending.pop_front();
      if (b !== want.out_byte)
         report($sformatf("out_byte %02h, expected %02h", b, want.out_byte));
      if (last !== want.last_of_run)
         report($sformatf("last_of_run %0b, expected %0b", last, want.last_of_run));
      if (le !== want.line_end)
         report($sformatf("line_end %0b, expected %0b", le, want.line_end));
   endtask
endclass

module testbench;

   localparam int DIRECTED_LEN   = 28;
   localparam int RANDOM_ITEMS   = 332;
   localparam int WATCHDOG_LIMIT = 2000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       rsp_line_end;

   line_scoreboard board;
   bit  req_busy = 1'b0;
   int  sent = 0;
   int  quiet_cycles = 0;
   int  hold_left = 0;
   int  free_left = 0;

   // leading blanks, space before quote, end inside quotes; zero after
   // backslash; zero after caret; name ended by star, escapes, extremes,
   // space before separator, comment
   logic [7:0] directed [DIRECTED_LEN] = '{
      clp_pkg::CHAR_SPACE, 8'h61, clp_pkg::CHAR_SPACE, clp_pkg::CHAR_TAB,
      clp_pkg::CHAR_QUOTE, 8'h71, clp_pkg::CHAR_NUL,
      clp_pkg::CHAR_BACKSLASH, clp_pkg::CHAR_NUL,
      clp_pkg::CHAR_CARET, clp_pkg::CHAR_NUL,
      clp_pkg::CHAR_DOLLAR, 8'h78, clp_pkg::CHAR_UNDERLINE, 8'h39, clp_pkg::CHAR_STAR,
      clp_pkg::CHAR_BACKSLASH,
      clp_pkg::CHAR_SPACE, clp_pkg::CHAR_CARET, 8'hFF, clp_pkg::MARKER, 8'h7F,
      clp_pkg::CHAR_SPACE, clp_pkg::CHAR_SEMICOLON,
      clp_pkg::CHAR_BAR, clp_pkg::CHAR_HASH, clp_pkg::CHAR_QUESTION, clp_pkg::CHAR_NUL
   };

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   command_line_preformatter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_line_end    (rsp_line_end)
   );

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = req_busy ? 0 : idle_length();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_in_byte = b;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_byte(b);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_line();
      int len;
      int pick;
      int name_len;
      len = $urandom_range(0, 16);
      req_busy = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_byte(($urandom_range(0, 1) ? LOWER_A : UPPER_A) + 8'($urandom_range(0, 25)));
         end else if (pick < 38) begin
            send_byte(DIGIT_0 + 8'($urandom_range(0, 9)));
         end else if (pick < 52) begin
            send_byte($urandom_range(0, 1) ? clp_pkg::CHAR_SPACE : clp_pkg::CHAR_TAB);
         end else if (pick < 56) begin
            send_byte($urandom_range(0, 1) ? clp_pkg::CHAR_STAR : clp_pkg::CHAR_QUESTION);
         end else if (pick < 61) begin
            send_byte($urandom_range(0, 1) ? clp_pkg::CHAR_SEMICOLON : clp_pkg::CHAR_BAR);
         end else if (pick < 66) begin
            send_byte(clp_pkg::CHAR_QUOTE);
         end else if (pick < 75) begin
            // escape or mask any byte, zero included
            send_byte(pick < 71 ? clp_pkg::CHAR_BACKSLASH : clp_pkg::CHAR_CARET);
            send_byte(8'($urandom_range(0, 255)));
         end else if (pick < 83) begin
            send_byte(clp_pkg::CHAR_DOLLAR);
            name_len = $urandom_range(0, 4);
            for (int j = 0; j < name_len; j++)
               send_byte($urandom_range(0, 3) == 0 ? clp_pkg::CHAR_UNDERLINE :
                         LOWER_A + 8'($urandom_range(0, 25)));
         end else if (pick < 85) begin
            send_byte(clp_pkg::CHAR_HASH);
         end else if (pick < 87) begin
            send_byte(clp_pkg::CHAR_UNDERLINE);
         end else begin
            send_byte(8'($urandom_range(1, 255)));
         end
      end
      send_byte(clp_pkg::CHAR_NUL);
   endtask

   // result side stalls: mostly short, a few long, with free-running stretches
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = 1'b0;
         if (free_left > 0) begin
            free_left--;
         end else begin
            hold_left = idle_length();
            free_left = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 6);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check(rsp_out_byte, rsp_last_of_run, rsp_line_end);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[command_line_preformatter] ERROR");
            $finish;
         end
      end
   end

   initial begin
      board = new();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIRECTED_LEN; i++)
         send_byte(directed[i]);
      while (sent < DIRECTED_LEN + RANDOM_ITEMS)
         send_line();
      req_valid = 1'b0;

      while (board.pending.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      if (board.errors == 0)
         $display("[command_line_preformatter] OK");
      else
         $display("[command_line_preformatter] ERROR");
      $finish;
   end

endmodule
